// ----- hdl/sorted_insertion_priority_queue_macros.svh -----
// assertion shorthands for the queue rtl
`ifndef SORTED_INSERTION_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_INSERTION_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication
`define SIQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("siq assertion failed");

// next-cycle implication
`define SIQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("siq assertion failed");

`endif

// ----- hdl/siq_pkg.sv -----
`default_nettype none

package siq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic               cmd;
      logic signed [31:0] in_num;
      logic signed [15:0] in_priority;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_num;
      logic signed [15:0] out_priority;
      logic               out_valid;
      logic        [1:0]  status;
      logic        [4:0]  count_after;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] num;
      logic signed [15:0] prio;
   } entry_type;

   // broadcast to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type new_entry;
   } ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/siq_cell.sv -----
`default_nettype none

module siq_cell
   import siq_pkg::*;
(
   input  wire logic      clock,
   input  wire ctrl_type  ctrl,
   input  wire logic      occupied,
   input  wire logic      left_keep,
   input  wire entry_type left_entry,
   input  wire entry_type right_entry,
   output logic           keep,
   output entry_type      entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // stays put on insert when it outranks or ties the new entry
   assign keep  = occupied && (entry_ff.prio >= ctrl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq) begin
         if (keep) begin
            entry_in = entry_ff;
         end else if (left_keep) begin
            entry_in = ctrl.new_entry;
         end else begin
            entry_in = left_entry;
         end
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

// ----- hdl/siq_rsp_buf.sv -----
`default_nettype none

module siq_rsp_buf
   import siq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rsp_type push_data,
   output logic         busy,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  wire logic    rsp_stall
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_free;

   assign main_free = !main_valid_ff || !rsp_stall;
   assign busy      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

// ----- hdl/sorted_insertion_priority_queue.sv -----
// Bounded priority queue of CAPACITY entries (payload plus signed 16-bit
// priority) held sorted in a row of compare-and-shift cells, head in cell 0.
// Each request beat (enqueue or dequeue) updates all cells at once: on enqueue
// each cell compares its priority with the broadcast entry and either holds,
// takes the new entry or takes its left neighbor; on dequeue every cell takes
// its right neighbor. Equal priorities leave in arrival order. A request beat
// can be taken every cycle; each response beat is registered and leaves from
// an output register backed by a one-deep skid stage, so a stalled response
// side only backs up the request side once both are full. Overflow and
// underflow are rejected with a status code and leave the contents alone.
// No clearing pass after reset: the count alone marks which cells hold data.
`default_nettype none
`include "sorted_insertion_priority_queue_macros.svh"

module sorted_insertion_priority_queue
   import siq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // occupancy count
   logic [COUNT_W-1:0] count_ff, count_in;

   logic      accept;
   logic      is_full_now, is_empty_now;
   logic      enq_ok, deq_ok;
   ctrl_type  ctrl;
   rsp_type   rsp_next;
   logic [31:0] count_ext;

   // cell row wiring
   logic      keep_w [CAPACITY];
   logic      occ_w  [CAPACITY];
   entry_type entry_w[CAPACITY];

   assign accept       = req_valid && !req_stall;
   assign is_full_now  = (count_ff == COUNT_W'(CAPACITY));
   assign is_empty_now = (count_ff == '0);
   assign enq_ok       = accept && (req_data.cmd == CMD_ENQ) && !is_full_now;
   assign deq_ok       = accept && (req_data.cmd == CMD_DEQ) && !is_empty_now;

   assign ctrl.enq                = enq_ok;
   assign ctrl.deq                = deq_ok;
   assign ctrl.new_entry.num      = req_data.in_num;
   assign ctrl.new_entry.prio     = req_data.in_priority;

   always_comb begin
      count_in = count_ff;
      if (enq_ok) begin
         count_in = count_ff + 1'b1;
      end else if (deq_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // the row: cell 0 is the head
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic      lk;
      entry_type le;
      entry_type re;

      assign occ_w[i] = (COUNT_W'(i) < count_ff);

      if (i == 0) begin : g_first
         assign lk = 1'b1;
         assign le = ctrl.new_entry;
      end else begin : g_inner
         assign lk = keep_w[i-1];
         assign le = entry_w[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign re = entry_w[i];
      end else begin : g_body
         assign re = entry_w[i+1];
      end

      siq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ_w[i]),
         .left_keep   (lk),
         .left_entry  (le),
         .right_entry (re),
         .keep        (keep_w[i]),
         .entry       (entry_w[i])
      );
   end

   // response for this beat: head and status from the state before the request, count and flags from the state after it
   assign count_ext = 32'(count_in);

   always_comb begin
      rsp_next.out_num      = '0;
      rsp_next.out_priority = '0;
      rsp_next.out_valid    = 1'b0;
      rsp_next.status       = ST_OK;
      rsp_next.count_after  = count_ext[4:0];
      rsp_next.is_empty     = (count_in == '0);
      rsp_next.is_full      = (count_in == COUNT_W'(CAPACITY));
      if (req_data.cmd == CMD_ENQ) begin
         if (is_full_now) begin
            rsp_next.status = ST_OVERFLOW;
         end
      end else if (is_empty_now) begin
         rsp_next.status = ST_UNDERFLOW;
      end else begin
         rsp_next.out_num      = entry_w[0].num;
         rsp_next.out_priority = entry_w[0].prio;
         rsp_next.out_valid    = 1'b1;
      end
   end

   siq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (rsp_next),
      .busy      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   `SIQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= COUNT_W'(CAPACITY))
   `SIQ_ASSERT_NOW(a_head_sorted, clock, reset, count_ff >= COUNT_W'(2),
                   entry_w[0].prio >= entry_w[1].prio)
   `SIQ_ASSERT_NEXT(a_enq_count, clock, reset, enq_ok, count_ff == $past(count_ff) + 1'b1)
   `SIQ_ASSERT_NEXT(a_deq_count, clock, reset, deq_ok, count_ff == $past(count_ff) - 1'b1)
   `SIQ_ASSERT_NEXT(a_reject_hold, clock, reset, accept && !enq_ok && !deq_ok, $stable(count_ff))

endmodule

`default_nettype wire
